[hdl/lru_pkg.sv]
// Shared constants and types for the LRU age replacement block.
package lru_pkg;

	localparam int FRAMES       = 16;
	localparam int AGE_BITS     = 16;
	localparam int WAY_W        = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int COUNT_W      = $clog2(FRAMES + 1);
	localparam int CFG_W        = 5;
	localparam int HIT_WAY_W    = 4;
	localparam int VICTIM_WAY_W = 4;
	localparam int VICTIM_AGE_W = 16;

	localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};
	localparam logic [CFG_W-1:0]    FRAME_COUNT_RST = CFG_W'(16);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

[hdl/lru_if.sv]
// Request and response channel interfaces for the LRU age replacement block.
interface lru_req_if;
	logic                           valid;
	logic                           ready;
	logic                           is_hit;
	logic [lru_pkg::HIT_WAY_W-1:0]  hit_way;

	modport source (output valid, output is_hit, output hit_way, input ready);
	modport sink   (input valid, input is_hit, input hit_way, output ready);
endinterface

interface lru_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [lru_pkg::VICTIM_WAY_W-1:0]  victim_way;
	logic [lru_pkg::VICTIM_AGE_W-1:0]  victim_age;

	modport source (output valid, output victim_way, output victim_age, input ready);
	modport sink   (input valid, input victim_way, input victim_age, output ready);
endinterface

[hdl/lru_age_replacement.sv]
// Top level: LRU victim selection with per-frame age counters held in a RAM.
//
// req carries one page reference (is_hit, hit_way); rsp returns one result
// per request: the next victim frame and its age. cfg_we/cfg_data set the
// number of frames in use (0 acts as 1, above FRAMES acts as FRAMES); write
// it only while no request is in flight.
// Each request scans the in-use frames through the age RAM, one frame per
// cycle: a read is issued each cycle and the returned age is updated, written
// back and compared against the running maximum the next cycle. A new request
// is taken only in the idle state, once the previous scan has ended and its
// response is loaded; the scan loop over the age RAM, one read and one
// write per cycle, sets how often requests can be taken.
// The response sits in an output register; the next request is accepted
// while it waits. If the receiver is still stalling when the following scan
// ends, the block holds in its final state until the register frees up.
// Reset (arst_n low) clears the victim pointer, the output register and the
// per-frame valid bits, so every age reads as zero; frame count resets to 16.
module lru_age_replacement (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [lru_pkg::CFG_W-1:0]  cfg_data,
	lru_req_if.sink                    req,
	lru_rsp_if.source                  rsp
);

	localparam int WAY_W    = lru_pkg::WAY_W;
	localparam int COUNT_W  = lru_pkg::COUNT_W;
	localparam int AGE_BITS = lru_pkg::AGE_BITS;

	lru_pkg::state_t state_q, state_d;

	logic [lru_pkg::CFG_W-1:0]           fc_q;
	logic [COUNT_W-1:0]                  n_c;
	logic [COUNT_W-1:0]                  cnt_q;
	logic [WAY_W-1:0]                    vp_q;
	logic                                miss_q;
	logic                                hit_q;
	logic [lru_pkg::HIT_WAY_W-1:0]       way_q;

	logic [AGE_BITS-1:0]                 mem [lru_pkg::FRAMES];
	logic [lru_pkg::FRAMES-1:0]          vld_q;
	logic                                rd_en;
	logic                                rd_v_s1;
	logic                                rd_ok_s1;
	logic [WAY_W-1:0]                    rd_idx_s1;
	logic [AGE_BITS-1:0]                 rd_data_s1;
	logic [AGE_BITS-1:0]                 age_cur;
	logic [AGE_BITS-1:0]                 age_new;

	logic [AGE_BITS-1:0]                 best_q;
	logic [WAY_W-1:0]                    pick_q;
	logic                                found_q;
	logic [WAY_W-1:0]                    vp_next;

	logic                                out_v_q;
	logic [lru_pkg::VICTIM_WAY_W-1:0]    out_way_q;
	logic [lru_pkg::VICTIM_AGE_W-1:0]    out_age_q;
	logic                                load_out;
	logic                                req_acc;
	logic                                scan_last;

	// frames in use, clamped to 1..FRAMES
	always_comb begin
		if (fc_q == '0) begin
			n_c = COUNT_W'(1);
		end else if (32'(fc_q) > 32'(lru_pkg::FRAMES)) begin
			n_c = COUNT_W'(lru_pkg::FRAMES);
		end else begin
			n_c = COUNT_W'(fc_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q <= lru_pkg::FRAME_COUNT_RST;
		end else if (cfg_we) begin
			fc_q <= cfg_data;
		end
	end

	assign req_acc   = req.valid && req.ready;
	assign scan_last = rd_v_s1 && (cnt_q == n_c);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lru_pkg::ST_IDLE: begin
				if (req.valid) begin
					state_d = lru_pkg::ST_SCAN;
				end
			end
			lru_pkg::ST_SCAN: begin
				if (scan_last) begin
					state_d = lru_pkg::ST_DONE;
				end
			end
			lru_pkg::ST_DONE: begin
				if (!out_v_q || rsp.ready) begin
					state_d = lru_pkg::ST_IDLE;
				end
			end
			default: state_d = lru_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		req.ready = 1'b0;
		rd_en     = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			lru_pkg::ST_IDLE: req.ready = 1'b1;
			lru_pkg::ST_SCAN: rd_en = (cnt_q < n_c);
			lru_pkg::ST_DONE: load_out = !out_v_q || rsp.ready;
			default: req.ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lru_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// request capture; a miss restarts the current victim, which is in use
	// exactly when the scan reaches its index
	always_ff @(posedge clk) begin
		if (req_acc) begin
			miss_q <= !req.is_hit;
			hit_q  <= req.is_hit;
			way_q  <= req.hit_way;
		end
	end

	// read side of the age RAM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			if (req_acc) begin
				cnt_q <= '0;
			end else if (rd_en) begin
				cnt_q <= cnt_q + COUNT_W'(1);
			end
			rd_v_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[cnt_q[WAY_W-1:0]];
			rd_ok_s1   <= vld_q[cnt_q[WAY_W-1:0]];
			rd_idx_s1  <= cnt_q[WAY_W-1:0];
		end
	end

	// age update for the entry just read
	always_comb begin
		age_cur = rd_ok_s1 ? rd_data_s1 : '0;
		if ((miss_q && rd_idx_s1 == vp_q) ||
		    (hit_q && COUNT_W'(rd_idx_s1) == COUNT_W'(way_q))) begin
			age_new = '0;
		end else if (age_cur == lru_pkg::AGE_MAX) begin
			age_new = age_cur;
		end else begin
			age_new = age_cur + AGE_BITS'(1);
		end
	end

	// write back; the next read is always a higher index, so no overlap
	always_ff @(posedge clk) begin
		if (rd_v_s1) begin
			mem[rd_idx_s1] <= age_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (rd_v_s1) begin
			vld_q[rd_idx_s1] <= 1'b1;
		end
	end

	// running maximum, lowest index wins ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (req_acc) begin
			found_q <= 1'b0;
		end else if (rd_v_s1 && age_new > best_q) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			best_q <= '0;
			pick_q <= '0;
		end else if (rd_v_s1 && age_new > best_q) begin
			best_q <= age_new;
			pick_q <= rd_idx_s1;
		end
	end

	always_comb begin
		if (found_q) begin
			vp_next = pick_q;
		end else if (COUNT_W'(vp_q) >= n_c) begin
			vp_next = '0;
		end else begin
			vp_next = vp_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vp_q <= '0;
		end else if (load_out) begin
			vp_q <= vp_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load_out) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	// with no age above zero every in-use age is zero
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_way_q <= lru_pkg::VICTIM_WAY_W'(vp_next);
			out_age_q <= found_q ? lru_pkg::VICTIM_AGE_W'(best_q) : '0;
		end
	end

	assign rsp.valid      = out_v_q;
	assign rsp.victim_way = out_way_q;
	assign rsp.victim_age = out_age_q;

endmodule

[hdl/lru_checker.sv]
// Port-level checks for the LRU age replacement block, bound to the top level.
module lru_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	input  logic                              req_ready,
	input  logic                              rsp_valid,
	input  logic                              rsp_ready,
	input  logic [lru_pkg::VICTIM_WAY_W-1:0]  victim_way,
	input  logic [lru_pkg::VICTIM_AGE_W-1:0]  victim_age
);

	// a stalled response holds its value
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(victim_way) && $stable(victim_age))
		else $error("response changed while stalled");

	// the scan keeps the block busy after a request is taken
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready ##1 !req_ready)
		else $error("request taken during scan");

	// a new response only appears after a busy cycle
	a_rsp_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("response without a scan");

endmodule

bind lru_age_replacement lru_checker u_lru_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.victim_way (rsp.victim_way),
	.victim_age (rsp.victim_age)
);

[tb/sv/lru_age_replacement_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the LRU age replacement block: table, then random phases.
module lru_age_replacement_test;

	localparam int REFS_PER_SETTING = 120;
	localparam int WATCHDOG_LIMIT   = 4000;
	localparam int SETTLE_CYCLES    = lru_pkg::FRAMES + 4;
	localparam int MAX_PRINTED      = 100;

	localparam int FRAME_PLAN [9] = '{16, 1, 0, 31, 7, 17, 4, 16, 12};
	localparam int SEND_IDLE  [4] = '{0, 81, 0, 30};
	localparam int RECV_STALL [4] = '{0, 0, 81, 30};

	typedef struct packed {
		logic [lru_pkg::VICTIM_WAY_W-1:0] way;
		logic [lru_pkg::VICTIM_AGE_W-1:0] age;
	} victim_t;

	typedef enum logic {ROW_REF, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t                       kind;
		logic [lru_pkg::CFG_W-1:0]       frames;
		logic                            is_hit;
		logic [lru_pkg::HIT_WAY_W-1:0]   hit_way;
		logic                            known;
		victim_t                         victim;
	} dir_row_t;

	// known rows carry the victim typed in; the rest go through the predictor
	dir_row_t directed_refs [25] = '{
		'{ROW_REF, 5'd0,  1'b0, 4'd0,  1'b1, '{4'd1, 16'd1}},
		'{ROW_REF, 5'd0,  1'b1, 4'd15, 1'b1, '{4'd1, 16'd2}},
		'{ROW_REF, 5'd0,  1'b1, 4'd1,  1'b1, '{4'd2, 16'd3}},
		'{ROW_REF, 5'd0,  1'b0, 4'd0,  1'b0, '{4'd0, 16'd0}},
		'{ROW_CFG, 5'd0,  1'b0, 4'd0,  1'b0, '{4'd0, 16'd0}},
		'{ROW_REF, 5'd0,  1'b0, 4'd0,  1'b0, '{4'd0, 16'd0}},
		'{ROW_REF, 5'd0,  1'b1, 4'd9,  1'b0, '{4'd0, 16'd0}},
		'{ROW_REF, 5'd0,  1'b1, 4'd0,  1'b1, '{4'd0, 16'd0}},
		'{ROW_REF, 5'd0,  1'b0, 4'd0,  1'b1, '{4'd0, 16'd0}},
		'{ROW_CFG, 5'd31, 1'b0, 4'd0,  1'b0, '{4'd0, 16'd0}},
		'{ROW_REF, 5'd0,  1'b1, 4'd0,  1'b0, '{4'd0, 16'd0}},
		'{ROW_REF, 5'd0,  1'b0, 4'd0,  1'b0, '{4'd0, 16'd0}},
		'{ROW_REF, 5'd0,  1'b1, 4'd15, 1'b0, '{4'd0, 16'd0}},
		'{ROW_REF, 5'd0,  1'b0, 4'd5,  1'b0, '{4'd0, 16'd0}},
		'{ROW_CFG, 5'd1,  1'b0, 4'd0,  1'b0, '{4'd0, 16'd0}},
		'{ROW_REF, 5'd0,  1'b1, 4'd0,  1'b1, '{4'd0, 16'd0}},
		'{ROW_CFG, 5'd17, 1'b0, 4'd0,  1'b0, '{4'd0, 16'd0}},
		'{ROW_REF, 5'd0,  1'b0, 4'd0,  1'b0, '{4'd0, 16'd0}},
		'{ROW_REF, 5'd0,  1'b1, 4'd7,  1'b0, '{4'd0, 16'd0}},
		'{ROW_REF, 5'd0,  1'b1, 4'd8,  1'b0, '{4'd0, 16'd0}},
		'{ROW_CFG, 5'd4,  1'b0, 4'd0,  1'b0, '{4'd0, 16'd0}},
		'{ROW_REF, 5'd0,  1'b1, 4'd12, 1'b0, '{4'd0, 16'd0}},
		'{ROW_REF, 5'd0,  1'b0, 4'd0,  1'b0, '{4'd0, 16'd0}},
		'{ROW_REF, 5'd0,  1'b1, 4'd3,  1'b0, '{4'd0, 16'd0}},
		'{ROW_REF, 5'd0,  1'b0, 4'd10, 1'b0, '{4'd0, 16'd0}}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [lru_pkg::CFG_W-1:0] cfg_data;

	lru_req_if req_ch ();
	lru_rsp_if rsp_ch ();

	lru_age_replacement dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow state of the block
	logic [lru_pkg::AGE_BITS-1:0] age_model [lru_pkg::FRAMES];
	int                           victim_model;
	logic [lru_pkg::CFG_W-1:0]    frames_model;

	victim_t victim_q [$];
	int      errors = 0;
	int      idle_cycles = 0;
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;

	task automatic report(string msg);
		errors++;
		if (errors <= MAX_PRINTED)
			$display("ERROR at %0t: %s", $time, msg);
	endtask

	function automatic int frames_in_use();
		if (frames_model == 0)
			return 1;
		if (frames_model > lru_pkg::FRAMES)
			return lru_pkg::FRAMES;
		return int'(frames_model);
	endfunction

	function automatic victim_t next_victim(logic is_hit,
			logic [lru_pkg::HIT_WAY_W-1:0] hit_way);
		int                           n;
		logic                         restart;
		logic [lru_pkg::AGE_BITS-1:0] best;
		logic                         found;
		int                           pick;
		victim_t                      res;
		n = frames_in_use();
		restart = !is_hit && victim_model < n;
		for (int i = 0; i < n; i++) begin
			if (restart && i == victim_model)
				age_model[i] = '0;
			else if (age_model[i] != lru_pkg::AGE_MAX)
				age_model[i] = age_model[i] + 1'b1;
		end
		if (is_hit && int'(hit_way) < n)
			age_model[hit_way] = '0;
		best = '0;
		found = 1'b0;
		pick = 0;
		for (int i = 0; i < n; i++) begin
			if (age_model[i] > best) begin
				best = age_model[i];
				pick = i;
				found = 1'b1;
			end
		end
		if (found)
			victim_model = pick;
		else if (victim_model >= n)
			victim_model = 0;
		res.way = lru_pkg::VICTIM_WAY_W'(victim_model);
		res.age = lru_pkg::VICTIM_AGE_W'(age_model[victim_model]);
		return res;
	endfunction

	// one request; returns at the edge where it was taken, valid still high
	task automatic send_ref(logic is_hit, logic [lru_pkg::HIT_WAY_W-1:0] hit_way,
			logic known, victim_t typed);
		victim_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.is_hit  <= is_hit;
		req_ch.hit_way <= hit_way;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		predicted = next_victim(is_hit, hit_way);
		victim_q.push_back(known ? typed : predicted);
	endtask

	task automatic quiesce();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (victim_q.size() != 0);
	endtask

	task automatic write_frames(logic [lru_pkg::CFG_W-1:0] value);
		quiesce();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		frames_model = value;
	endtask

	always @(posedge clk)
		rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

	always @(posedge clk) begin : check_victims
		victim_t want;
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				if (victim_q.size() == 0) begin
					report($sformatf("response way %0d age %0d with no request outstanding",
						rsp_ch.victim_way, rsp_ch.victim_age));
				end else begin
					want = victim_q.pop_front();
					if (rsp_ch.victim_way !== want.way)
						report($sformatf("victim_way got %0d, want %0d",
							rsp_ch.victim_way, want.way));
					if (rsp_ch.victim_age !== want.age)
						report($sformatf("victim_age got %0d, want %0d",
							rsp_ch.victim_age, want.age));
				end
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		int                            k;
		int                            n;
		logic                          hit;
		logic [lru_pkg::HIT_WAY_W-1:0] way;
		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_data       <= '0;
		req_ch.valid   <= 1'b0;
		req_ch.is_hit  <= 1'b0;
		req_ch.hit_way <= '0;
		for (int i = 0; i < lru_pkg::FRAMES; i++)
			age_model[i] = '0;
		victim_model = 0;
		frames_model = lru_pkg::FRAME_COUNT_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_refs[r]) begin
			if (directed_refs[r].kind == ROW_CFG)
				write_frames(directed_refs[r].frames);
			else
				send_ref(directed_refs[r].is_hit, directed_refs[r].hit_way,
					directed_refs[r].known, directed_refs[r].victim);
		end

		for (int mode = 0; mode < 4; mode++) begin
			send_idle_pct = SEND_IDLE[mode];
			recv_stall_pct <= RECV_STALL[mode];
			for (int setting = 0; setting < 3; setting++) begin
				k = mode * 3 + setting;
				write_frames(k < 9 ? lru_pkg::CFG_W'(FRAME_PLAN[k]) :
					lru_pkg::CFG_W'($urandom_range(0, 31)));
				for (int i = 0; i < REFS_PER_SETTING; i++) begin
					if (mode == 3 && i == REFS_PER_SETTING / 2)
						quiesce();
					n = frames_in_use();
					hit = ($urandom_range(0, 99) < 65);
					// mostly frames in use, some anywhere
					if ($urandom_range(0, 3) != 0)
						way = lru_pkg::HIT_WAY_W'($urandom_range(0, n - 1));
					else
						way = lru_pkg::HIT_WAY_W'($urandom_range(0, 15));
					send_ref(hit, way, 1'b0, '0);
				end
			end
		end

		quiesce();
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && victim_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
